>>> rtl/ipv4_fragment_planner_core_assert.svh
// assertion macros for the fragment planner rtl
`ifndef IPV4_FRAGMENT_PLANNER_CORE_ASSERT_SVH
`define IPV4_FRAGMENT_PLANNER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define IFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ifp_pkg.sv
// types, constants and microcode table of the ipv4 fragment planner
`default_nettype none

package ifp_pkg;

	localparam logic [5:0]  BASE_HDR    = 6'd20;
	localparam logic [15:0] WHOLE_IDENT = 16'h0800;
	localparam logic [13:0] MTU_MIN     = 14'd1088;
	localparam logic [13:0] MTU_MAX     = 14'd9216;
	localparam logic [13:0] MTU_RESET   = 14'd1500;
	localparam logic [13:0] MAXP_MASK   = 14'h3FF8;
	localparam logic [5:0]  FRAG_LAST_K = 6'd63;

	typedef logic [3:0] pc_t;

	localparam pc_t STEP_LOAD  = 4'd0;
	localparam pc_t STEP_CHECK = 4'd1;
	localparam pc_t STEP_TAKE  = 4'd2;
	localparam pc_t STEP_ICMPQ = 4'd3;
	localparam pc_t STEP_FRAG  = 4'd4;
	localparam pc_t STEP_DONE  = 4'd5;
	localparam pc_t STEP_WHOLE = 4'd6;
	localparam pc_t STEP_DROP  = 4'd7;
	localparam pc_t STEP_ICMP  = 4'd8;

	typedef enum logic [1:0] {
		ACT_FRAG  = 2'd0,
		ACT_WHOLE = 2'd1,
		ACT_DROP  = 2'd2,
		ACT_ICMP  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_TAKE,
		OP_FRAG,
		OP_WHOLE,
		OP_DROP,
		OP_ICMP
	} op_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_FITS,
		COND_DROP,
		COND_ICMP,
		COND_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	// condition inputs from the datapath to the sequencer
	typedef struct packed {
		logic in_valid;
		logic emit_ok;
		logic fits;
		logic drop;
		logic icmp;
		logic more;
	} seq_flags_t;

	// control word handed to the datapath
	typedef struct packed {
		op_t  op;
		logic go;
	} seq_ctl_t;

	// branch is taken when cond holds, otherwise the step falls through
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			STEP_LOAD:  w = '{op: OP_LOAD,  cond: COND_ALWAYS, target: STEP_CHECK};
			STEP_CHECK: w = '{op: OP_NONE,  cond: COND_FITS,   target: STEP_WHOLE};
			STEP_TAKE:  w = '{op: OP_TAKE,  cond: COND_DROP,   target: STEP_DROP};
			STEP_ICMPQ: w = '{op: OP_NONE,  cond: COND_ICMP,   target: STEP_ICMP};
			STEP_FRAG:  w = '{op: OP_FRAG,  cond: COND_MORE,   target: STEP_FRAG};
			STEP_DONE:  w = '{op: OP_NONE,  cond: COND_ALWAYS, target: STEP_LOAD};
			STEP_WHOLE: w = '{op: OP_WHOLE, cond: COND_ALWAYS, target: STEP_LOAD};
			STEP_DROP:  w = '{op: OP_DROP,  cond: COND_ALWAYS, target: STEP_LOAD};
			STEP_ICMP:  w = '{op: OP_ICMP,  cond: COND_ALWAYS, target: STEP_LOAD};
			default:    w = '{op: OP_NONE,  cond: COND_ALWAYS, target: STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ifp_seq.sv
// microcode sequencer: step counter, control table and branch logic
`default_nettype none

module ifp_seq
	import ifp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire seq_flags_t flags,
	output seq_ctl_t        ctl
);

	pc_t    pc_q;
	ucode_t uw;
	logic   ready;
	logic   taken;

	assign uw = ucode_rom(pc_q);

	always_comb begin
		// a step waits for its handshake partner before it executes
		unique case (uw.op)
			OP_LOAD:  ready = flags.in_valid;
			OP_FRAG,
			OP_WHOLE,
			OP_DROP,
			OP_ICMP:  ready = flags.emit_ok;
			default:  ready = 1'b1;
		endcase

		unique case (uw.cond)
			COND_ALWAYS: taken = 1'b1;
			COND_FITS:   taken = flags.fits;
			COND_DROP:   taken = flags.drop;
			COND_ICMP:   taken = flags.icmp;
			COND_MORE:   taken = flags.more;
			default:     taken = 1'b1;
		endcase
	end

	assign ctl.op = uw.op;
	assign ctl.go = ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
		end else if (ready) begin
			pc_q <= taken ? uw.target : pc_t'(pc_q + 4'd1);
		end
	end

endmodule

`default_nettype wire

>>> rtl/ipv4_fragment_planner_core.sv
// sequence: load and check steps, then a whole word; or load, check, take, then a drop
// word; or load, check, take, icmp query, then an icmp word or up to 64 fragments, one
// per cycle while the receiver does not stall, and a done step; steps run one per cycle
// unless a step waits on its handshake; the next input word waits for the last step
// reset: asynchronous, clears step counter, output valid and ident counter, mtu 1500
`default_nettype none

module ipv4_fragment_planner_core
	import ifp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [13:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [15:0] packet_len,
	input  wire logic [5:0]  header_len,
	input  wire logic [15:0] frag_field,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       action,
	output logic [15:0]      read_offset,
	output logic [13:0]      frag_payload_len,
	output logic [15:0]      total_length,
	output logic [13:0]      flags_offset,
	output logic [5:0]       hdr_bytes,
	output logic [15:0]      ident,
	output logic [13:0]      reported_mtu,
	output logic             last
);

	`include "ipv4_fragment_planner_core_assert.svh"

	seq_flags_t flags;
	seq_ctl_t   ctl;

	logic [13:0] link_mtu_q;
	logic [15:0] next_ident_q;
	logic        out_valid_q;

	logic        type_q;
	logic [15:0] plen_q;
	logic [5:0]  hlen_q;
	logic [15:0] frag_q;
	logic [13:0] mtu_q;
	logic [15:0] id_q;
	logic [16:0] off_q;
	logic [15:0] total_q;
	logic [5:0]  hl_q;
	logic [5:0]  skip_q;
	logic [13:0] maxp_q;
	logic [5:0]  k_q;

	logic [5:0]  hlen_in;
	logic [13:0] mtu_in;
	logic [5:0]  hfirst;
	logic [16:0] rem;
	logic [13:0] pl;
	logic [16:0] nxt;
	logic        mf;
	logic        emit;

	ifp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (ctl.op != OP_LOAD);
	assign out_valid = out_valid_q;

	// header length in words of four, at least the base header
	assign hlen_in = ({header_len[5:2], 2'b00} < BASE_HDR) ? BASE_HDR
		: {header_len[5:2], 2'b00};
	assign mtu_in = (link_mtu_q < MTU_MIN) ? MTU_MIN
		: ((link_mtu_q > MTU_MAX) ? MTU_MAX : link_mtu_q);

	assign hfirst = type_q ? hlen_q : BASE_HDR;
	assign rem    = {1'b0, total_q} - off_q;
	assign pl     = (rem < {3'b000, maxp_q}) ? rem[13:0] : maxp_q;
	assign nxt    = off_q + {3'b000, maxp_q};
	assign mf     = (nxt < {1'b0, total_q});

	assign flags.in_valid = in_valid;
	assign flags.emit_ok  = !out_valid_q || !out_stall;
	assign flags.fits     = type_q ? (plen_q <= {2'b00, mtu_q})
		: (({1'b0, plen_q} + 17'd20) <= {3'b000, mtu_q});
	assign flags.drop     = type_q && (frag_q[12:0] != 13'd0);
	assign flags.icmp     = type_q && (frag_q[14:13] != 2'b00);
	assign flags.more     = mf && (k_q != FRAG_LAST_K);

	assign emit = ctl.go && ((ctl.op == OP_FRAG) || (ctl.op == OP_WHOLE)
		|| (ctl.op == OP_DROP) || (ctl.op == OP_ICMP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mtu_q   <= MTU_RESET;
			next_ident_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				link_mtu_q <= cfg_data;
			if (ctl.go && (ctl.op == OP_TAKE))
				next_ident_q <= next_ident_q + 16'd1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// working registers of the datapath
	always_ff @(posedge clk) begin
		if (ctl.go) begin
			unique case (ctl.op)
				OP_LOAD: begin
					type_q <= req_type;
					plen_q <= packet_len;
					hlen_q <= hlen_in;
					frag_q <= frag_field;
					mtu_q  <= mtu_in;
				end
				OP_TAKE: begin
					id_q    <= next_ident_q;
					off_q   <= '0;
					k_q     <= '0;
					hl_q    <= hfirst;
					skip_q  <= type_q ? hlen_q : 6'd0;
					total_q <= type_q ? (plen_q - {10'd0, hlen_q}) : plen_q;
					maxp_q  <= (mtu_q - {8'd0, hfirst}) & MAXP_MASK;
				end
				OP_FRAG: begin
					off_q  <= nxt;
					k_q    <= k_q + 6'd1;
					hl_q   <= BASE_HDR;
					maxp_q <= (mtu_q - {8'd0, BASE_HDR}) & MAXP_MASK;
				end
				default: begin
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			read_offset      <= '0;
			frag_payload_len <= '0;
			total_length     <= '0;
			flags_offset     <= '0;
			hdr_bytes        <= '0;
			ident            <= '0;
			reported_mtu     <= '0;
			last             <= 1'b1;
			unique case (ctl.op)
				OP_FRAG: begin
					action           <= ACT_FRAG;
					read_offset      <= off_q[15:0] + {10'd0, skip_q};
					frag_payload_len <= pl;
					total_length     <= {10'd0, hl_q} + {2'b00, pl};
					flags_offset     <= {mf, off_q[15:3]};
					hdr_bytes        <= hl_q;
					ident            <= id_q;
					last             <= !mf;
				end
				OP_WHOLE: begin
					action <= ACT_WHOLE;
					if (type_q) begin
						frag_payload_len <= (plen_q >= {10'd0, hlen_q})
							? 14'(plen_q - {10'd0, hlen_q}) : 14'd0;
						total_length     <= plen_q;
						flags_offset     <= frag_q[13:0];
						hdr_bytes        <= hlen_q;
					end else begin
						frag_payload_len <= plen_q[13:0];
						total_length     <= plen_q + 16'd20;
						hdr_bytes        <= BASE_HDR;
						ident            <= WHOLE_IDENT;
					end
				end
				OP_DROP: begin
					action <= ACT_DROP;
				end
				default: begin
					action       <= ACT_ICMP;
					reported_mtu <= mtu_q;
				end
			endcase
		end
	end

	`IFP_ASSERT_NEXT(a_one_word_in, clk, arst_n, in_valid && !in_stall, in_stall, "second input word taken before first was planned")
	`IFP_ASSERT_NOW(a_not_last_is_frag, clk, arst_n, out_valid && !last, action == ACT_FRAG, "non-final word is not a fragment")
	`IFP_ASSERT_NOW(a_mtu_only_icmp, clk, arst_n, out_valid && (action != ACT_ICMP), reported_mtu == 14'd0, "mtu reported outside icmp word")
	`IFP_ASSERT_NEXT(a_ident_step, clk, arst_n, 1'b1, (next_ident_q == $past(next_ident_q)) || (next_ident_q == 16'($past(next_ident_q) + 16'd1)), "ident counter jumped")

endmodule

`default_nettype wire

>>> tb/ifp_tb_pkg.sv
// request codes and flag masks shared by the fragment planner testbench
package ifp_tb_pkg;

	localparam logic        REQ_LOCAL = 1'b0;
	localparam logic        REQ_FWD   = 1'b1;
	localparam logic [15:0] RSV_FLAG  = 16'h8000;
	localparam logic [15:0] DF_FLAG   = 16'h4000;
	localparam logic [15:0] MF_FLAG   = 16'h2000;
	localparam logic [15:0] OFF_FIELD = 16'h1FFF;
	localparam int          HDR_LIMIT = 60;

endpackage

>>> tb/ifp_plan_checker.sv
// checker: predicts fragment descriptors per datagram word and compares the output words
module ifp_plan_checker
	import ifp_pkg::*;
	import ifp_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        req_type,
	input  logic [15:0] packet_len,
	input  logic [5:0]  header_len,
	input  logic [15:0] frag_field,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  action,
	input  logic [15:0] read_offset,
	input  logic [13:0] frag_payload_len,
	input  logic [15:0] total_length,
	input  logic [13:0] flags_offset,
	input  logic [5:0]  hdr_bytes,
	input  logic [15:0] ident,
	input  logic [13:0] reported_mtu,
	input  logic        last,
	output int          pending,
	output int          errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		action_t     act;
		logic [15:0] rd_off;
		logic [13:0] pay_len;
		logic [15:0] tot_len;
		logic [13:0] flg_off;
		logic [5:0]  hdr;
		logic [15:0] id;
		logic [13:0] icmp_mtu;
		logic        lst;
	} frag_desc_t;

	frag_desc_t  desc_q[$];
	logic [13:0] link_mtu;
	logic [15:0] next_ident;
	int          mismatches = 0;

	assign errors = mismatches;

	function automatic void queue_desc(input action_t act, input int unsigned rd_off,
		input int unsigned pay_len, input int unsigned tot_len, input int unsigned flg_off,
		input int unsigned hdr, input int unsigned id, input int unsigned icmp_mtu,
		input bit lst);
		frag_desc_t d;
		d.act      = act;
		d.rd_off   = rd_off[15:0];
		d.pay_len  = pay_len[13:0];
		d.tot_len  = tot_len[15:0];
		d.flg_off  = flg_off[13:0];
		d.hdr      = hdr[5:0];
		d.id       = id[15:0];
		d.icmp_mtu = icmp_mtu[13:0];
		d.lst      = lst;
		desc_q.push_back(d);
	endfunction

	// first fragment carries hfirst header bytes, later ones the base header
	function automatic void queue_fragments(input int unsigned mtu, input int unsigned total,
		input int unsigned hfirst, input int unsigned skip, input logic [15:0] id);
		int unsigned off, hdr, maxp, pl, more, k;
		off  = 0;
		hdr  = hfirst;
		maxp = (mtu - hfirst) & ~32'd7;
		k    = 0;
		while (off < total && k < 64) begin
			pl   = (total - off < maxp) ? total - off : maxp;
			more = (off + maxp < total) ? 32'(MF_FLAG) : 32'd0;
			queue_desc(ACT_FRAG, off + skip, pl, hdr + pl, more | ((off >> 3) & OFF_FIELD),
				hdr, id, 0, off + maxp >= total);
			k++;
			off  = off + maxp;
			hdr  = 32'(BASE_HDR);
			maxp = (mtu - BASE_HDR) & ~32'd7;
		end
	endfunction

	function automatic void plan_datagram(input logic kind, input logic [15:0] plen_w,
		input logic [5:0] hlen_w, input logic [15:0] ff);
		int unsigned mtu, hl, plen;
		logic [15:0] id;
		bit          oversize;
		mtu = 32'(link_mtu);
		if (mtu < MTU_MIN) mtu = 32'(MTU_MIN);
		if (mtu > MTU_MAX) mtu = 32'(MTU_MAX);
		hl = 32'({hlen_w[5:2], 2'b00});
		if (hl < BASE_HDR) hl = 32'(BASE_HDR);
		if (hl > HDR_LIMIT) hl = HDR_LIMIT;
		plen = 32'(plen_w);
		oversize = (kind == REQ_FWD) ? (plen > mtu) : (plen + BASE_HDR > mtu);
		// every oversize request consumes an ident, even drop and icmp
		id = next_ident;
		if (oversize) next_ident = next_ident + 16'd1;
		if (kind == REQ_LOCAL) begin
			if (oversize)
				queue_fragments(mtu, plen, BASE_HDR, 0, id);
			else
				queue_desc(ACT_WHOLE, 0, plen, plen + BASE_HDR, 0, BASE_HDR, WHOLE_IDENT, 0, 1);
		end else if (!oversize) begin
			queue_desc(ACT_WHOLE, 0, (plen >= hl) ? plen - hl : 0, plen, ff[13:0], hl, 0, 0, 1);
		end else if ((ff & OFF_FIELD) != 0) begin
			queue_desc(ACT_DROP, 0, 0, 0, 0, 0, 0, 0, 1);
		end else if ((ff & (DF_FLAG | MF_FLAG)) != 0) begin
			queue_desc(ACT_ICMP, 0, 0, 0, 0, 0, 0, mtu, 1);
		end else begin
			queue_fragments(mtu, plen - hl, hl, hl, id);
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frag_desc_t want;
		if (!arst_n) begin
			link_mtu   = MTU_RESET;
			next_ident = '0;
			desc_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				link_mtu = cfg_data;
			if (in_valid && !in_stall)
				plan_datagram(req_type, packet_len, header_len, frag_field);
			if (out_valid && !out_stall) begin
				if (desc_q.size() == 0) begin
					$display("%0t: output word with nothing expected, action %0d", $time,
						action);
					mismatches++;
				end else begin
					want = desc_q.pop_front();
					check_field("action", 16'(want.act), 16'(action));
					check_field("read_offset", want.rd_off, read_offset);
					check_field("frag_payload_len", 16'(want.pay_len), 16'(frag_payload_len));
					check_field("total_length", want.tot_len, total_length);
					check_field("flags_offset", 16'(want.flg_off), 16'(flags_offset));
					check_field("hdr_bytes", 16'(want.hdr), 16'(hdr_bytes));
					check_field("ident", want.id, ident);
					check_field("reported_mtu", 16'(want.icmp_mtu), 16'(reported_mtu));
					check_field("last", 16'(want.lst), 16'(last));
				end
			end
			pending <= desc_q.size();
		end
	end

endmodule

>>> tb/tb.sv
// testbench top: drives datagram words and mtu writes, applies back-pressure, gives the verdict
module tb;
	import ifp_pkg::*;
	import ifp_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WORDS_PER_STEP = 26;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [13:0] cfg_data   = '0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        req_type   = REQ_LOCAL;
	logic [15:0] packet_len = '0;
	logic [5:0]  header_len = '0;
	logic [15:0] frag_field = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  action;
	logic [15:0] read_offset;
	logic [13:0] frag_payload_len;
	logic [15:0] total_length;
	logic [13:0] flags_offset;
	logic [5:0]  hdr_bytes;
	logic [15:0] ident;
	logic [13:0] reported_mtu;
	logic        last;
	int          pending;
	int          errors;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cur_mtu     = int'(MTU_RESET);
	int idle_cycles = 0;
	int hold_left   = 0;
	bit hold_go     = 1'b0;
	bit hold_done   = 1'b0;

	ipv4_fragment_planner_core u_dut (.*);

	ifp_plan_checker u_chk (.*);

	always #1 clk = ~clk;

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic push_word(input logic kind, input logic [15:0] len, input logic [5:0] hl,
		input logic [15:0] ff);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		packet_len <= len;
		header_len <= hl;
		frag_field <= ff;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering words until every expected descriptor is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mtu(input logic [13:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mtu = int'(val);
		if (cur_mtu < MTU_MIN) cur_mtu = int'(MTU_MIN);
		if (cur_mtu > MTU_MAX) cur_mtu = int'(MTU_MAX);
	endtask

	initial begin
		logic [13:0] mtu_plan [6];
		logic        kind;
		logic [15:0] len, ff;
		logic [5:0]  hl;
		int          phase, n, r;

		mtu_plan[0] = MTU_MIN;
		mtu_plan[1] = MTU_MAX;
		mtu_plan[2] = 14'h3FFF;
		mtu_plan[3] = 14'd0;
		mtu_plan[4] = 14'($urandom_range(MTU_MIN, MTU_MAX));
		mtu_plan[5] = 14'($urandom_range(16383));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 9;
		rx_idle_pct = 63;

		// directed words at the reset mtu
		push_word(REQ_LOCAL, 16'd0, 6'd0, 16'h0000);
		push_word(REQ_LOCAL, 16'd1480, 6'd63, 16'hFFFF);
		push_word(REQ_LOCAL, 16'd1481, 6'd20, 16'h0000);
		push_word(REQ_LOCAL, 16'hFFFF, 6'd20, 16'h0000);
		push_word(REQ_LOCAL, 16'd1500, 6'h2A, 16'h0000);
		push_word(REQ_FWD, 16'd1500, 6'd20, 16'h0000);
		push_word(REQ_FWD, 16'd10, 6'd60, 16'hFFFF);
		push_word(REQ_FWD, 16'd0, 6'd0, OFF_FIELD);
		push_word(REQ_FWD, 16'd1501, 6'd20, 16'h0001);
		push_word(REQ_FWD, 16'hFFFF, 6'd60, 16'hFFFF);
		push_word(REQ_FWD, 16'd1501, 6'd20, DF_FLAG);
		push_word(REQ_FWD, 16'd1501, 6'd20, MF_FLAG);
		push_word(REQ_FWD, 16'hFFFF, 6'd60, RSV_FLAG);
		push_word(REQ_FWD, 16'd1521, 6'd20, 16'h0000);
		push_word(REQ_FWD, 16'd3000, 6'd0, 16'h0000);
		push_word(REQ_FWD, 16'd3000, 6'd63, 16'h0000);
		push_word(REQ_FWD, 16'd3000, 6'd45, 16'h0000);
		push_word(REQ_FWD, 16'd3000, 6'd23, 16'h0000);

		for (phase = 0; phase < 6; phase++) begin
			set_mtu(mtu_plan[phase]);
			tx_idle_pct = (phase < 2) ? 9 : (phase < 4) ? 63 : 0;
			rx_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 9 : 0;
			if (phase == 0)
				hold_go = 1'b1;
			for (n = 0; n < WORDS_PER_STEP; n++) begin
				if (phase == 2 && n == WORDS_PER_STEP / 2)
					drain();
				kind = 1'($urandom_range(1));
				hl   = 6'($urandom_range(63));
				r    = $urandom_range(99);
				if (r < 15)
					len = 16'($urandom_range(200));
				else if (r < 45)
					len = 16'(cur_mtu - 48 + int'($urandom_range(96)));
				else if (r < 85)
					len = 16'($urandom_range(cur_mtu + 1, 4 * cur_mtu));
				else if (r < 97)
					len = 16'($urandom_range(16'hFFFF));
				else
					len = 16'hFFFF;
				// mostly clean first fragments so forwarded datagrams get split
				r = $urandom_range(99);
				if (r < 55)
					ff = $urandom_range(1) ? RSV_FLAG : 16'h0000;
				else if (r < 65)
					ff = DF_FLAG | ($urandom_range(1) ? MF_FLAG : 16'h0000);
				else if (r < 75)
					ff = MF_FLAG;
				else if (r < 85)
					ff = (16'($urandom_range(7)) << 13) | 16'($urandom_range(1, 8191));
				else
					ff = 16'($urandom_range(16'hFFFF));
				push_word(kind, len, hl, ff);
			end
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
